// File: rtl/pci_pkg.sv
// Shared types and constants of the palette colour indexer.
package pci_pkg;

   // Default palette geometry
   localparam int MAX_PALETTE_ROWS_DEF = 16;
   localparam int MAX_PALETTE_COLS_DEF = 16;

   // Field widths
   localparam int CFG_WIDTH    = 5;
   localparam int ENTRY_WIDTH  = 4;
   localparam int CHAN_WIDTH   = 8;
   localparam int COLOR_WIDTH  = 3 * CHAN_WIDTH;
   localparam int CSR_IDX_WIDTH = 1;

   // Geometry arithmetic width (row, column and limits up to 256)
   localparam int GEOM_WIDTH = 9;
   // Address arithmetic width (row * columns + column up to 65535)
   localparam int ADDR_CALC_WIDTH = 17;

   localparam logic [CHAN_WIDTH-1:0] FULL_BYTE = 8'd255;
   localparam logic [CHAN_WIDTH-1:0] ZERO_BYTE = 8'd0;

   // Request commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROWS    = 1'b1;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] COLUMNS_RESET = 5'd16;
   localparam logic [CFG_WIDTH-1:0] ROWS_RESET    = 5'd16;

   typedef struct packed {
      logic                   command;
      logic [ENTRY_WIDTH-1:0] entry_row;
      logic [ENTRY_WIDTH-1:0] entry_col;
      logic [CHAN_WIDTH-1:0]  red;
      logic [CHAN_WIDTH-1:0]  green;
      logic [CHAN_WIDTH-1:0]  blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] out_first;
      logic [CHAN_WIDTH-1:0] out_second;
      logic [CHAN_WIDTH-1:0] out_third;
      logic [CHAN_WIDTH-1:0] out_alpha;
      logic                  matched;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } state_type;

endpackage

// File: rtl/palette_colour_indexer_top.sv
// Top level of the palette colour indexer: palette memory and search sequencer.
//
// Usage:
//  - Request channel: a request is taken at a clock edge with start high and
//    busy low. A load request (command 0) writes one palette entry in that
//    edge if inside the store, produces no response and leaves busy low.
//    A pixel request (command 1) starts a row-major search of the active grid.
//  - Response channel: rsp_valid is high for exactly one cycle with rsp_data;
//    the receiver cannot stall, so it must take every response.
//  - Register port: csr_we writes csr_wdata to register csr_index
//    (0 columns, 1 rows); write only while busy is low.
// Timing: the palette memory is read one entry per cycle while in ST_SCAN and
// each entry is compared in the cycle after its read. A match moves the
// sequencer to ST_REPLY, which raises rsp_valid; a miss over the whole grid
// passes ST_DRAIN, where the last entry is compared, on its way to ST_REPLY.
// An empty grid answers in the cycle after the request. busy is high from
// the request edge through the response cycle.
// Reset: clears the sequencer and sets both registers to 16. The palette
// memory is not cleared; load each searched entry before indexing pixels.
module palette_colour_indexer_top #(
   parameter int MAX_PALETTE_ROWS = pci_pkg::MAX_PALETTE_ROWS_DEF,
   parameter int MAX_PALETTE_COLS = pci_pkg::MAX_PALETTE_COLS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  pci_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   output pci_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [pci_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [pci_pkg::CFG_WIDTH-1:0]         csr_wdata
);

   localparam int Depth = MAX_PALETTE_ROWS * MAX_PALETTE_COLS;
   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int RowWidth = (MAX_PALETTE_ROWS > 1) ? $clog2(MAX_PALETTE_ROWS) : 1;
   localparam int ColWidth = (MAX_PALETTE_COLS > 1) ? $clog2(MAX_PALETTE_COLS) : 1;
   localparam int GW = pci_pkg::GEOM_WIDTH;
   localparam int AW = pci_pkg::ADDR_CALC_WIDTH;

   // Configuration registers
   logic [pci_pkg::CFG_WIDTH-1:0] columns_ff;
   logic [pci_pkg::CFG_WIDTH-1:0] rows_ff;

   // Sequencer
   pci_pkg::state_type state_ff, state_in;
   logic [RowWidth-1:0] row_ff, row_in;
   logic [ColWidth-1:0] col_ff, col_in;
   logic                issue;

   // Compare stage
   logic [pci_pkg::COLOR_WIDTH-1:0] pixel_ff;
   logic [pci_pkg::COLOR_WIDTH-1:0] rd_data_ff;
   logic                            cmp_valid_ff;
   logic [RowWidth-1:0]             cmp_row_ff;
   logic [ColWidth-1:0]             cmp_col_ff;

   // Result
   logic                found_ff;
   logic [RowWidth-1:0] res_row_ff;
   logic [ColWidth-1:0] res_col_ff;

   logic [pci_pkg::COLOR_WIDTH-1:0] palette_mem [Depth];

   logic                            req_accept;
   logic                            load_accept;
   logic                            pixel_accept;
   logic [pci_pkg::COLOR_WIDTH-1:0] req_colour;
   logic                            load_in_range;
   logic [AW-1:0]                   load_addr_calc;
   logic [AW-1:0]                   scan_addr_calc;
   logic [GW-1:0]                   rows_ext, cols_ext;
   logic [GW-1:0]                   lim_rows, lim_cols;
   logic [GW-1:0]                   lim_rows_m1, lim_cols_m1;
   logic                            grid_empty;
   logic                            last_col;
   logic                            last_issue;
   logic                            hit;

   assign req_accept   = start && !busy;
   assign load_accept  = req_accept && (req_data.command == pci_pkg::CMD_LOAD);
   assign pixel_accept = req_accept && (req_data.command == pci_pkg::CMD_PIXEL);
   assign req_colour   = {req_data.red, req_data.green, req_data.blue};

   // Drop loads that fall outside the store
   assign load_in_range = (GW'(req_data.entry_row) < GW'(MAX_PALETTE_ROWS)) &&
                          (GW'(req_data.entry_col) < GW'(MAX_PALETTE_COLS));
   assign load_addr_calc = AW'(req_data.entry_row) * AW'(MAX_PALETTE_COLS)
                         + AW'(req_data.entry_col);
   assign scan_addr_calc = AW'(row_ff) * AW'(MAX_PALETTE_COLS) + AW'(col_ff);

   // Saturate the active grid to the store size
   assign rows_ext    = GW'(rows_ff);
   assign cols_ext    = GW'(columns_ff);
   assign lim_rows    = (rows_ext > GW'(MAX_PALETTE_ROWS)) ? GW'(MAX_PALETTE_ROWS) : rows_ext;
   assign lim_cols    = (cols_ext > GW'(MAX_PALETTE_COLS)) ? GW'(MAX_PALETTE_COLS) : cols_ext;
   assign lim_rows_m1 = lim_rows - GW'(1);
   assign lim_cols_m1 = lim_cols - GW'(1);
   assign grid_empty  = (lim_rows == '0) || (lim_cols == '0);

   assign last_col   = (GW'(col_ff) == lim_cols_m1);
   assign last_issue = last_col && (GW'(row_ff) == lim_rows_m1);
   assign hit        = cmp_valid_ff && (rd_data_ff == pixel_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= pci_pkg::COLUMNS_RESET;
         rows_ff    <= pci_pkg::ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pci_pkg::CSR_COLUMNS: columns_ff <= csr_wdata;
            pci_pkg::CSR_ROWS:    rows_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pci_pkg::ST_IDLE: begin
            if (pixel_accept) begin
               state_in = grid_empty ? pci_pkg::ST_REPLY : pci_pkg::ST_SCAN;
            end
         end
         pci_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = pci_pkg::ST_REPLY;
            end else if (last_issue) begin
               state_in = pci_pkg::ST_DRAIN;
            end
         end
         pci_pkg::ST_DRAIN: state_in = pci_pkg::ST_REPLY;
         pci_pkg::ST_REPLY: state_in = pci_pkg::ST_IDLE;
         default:           state_in = pci_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         pci_pkg::ST_IDLE:  busy      = 1'b0;
         pci_pkg::ST_SCAN:  issue     = 1'b1;
         pci_pkg::ST_DRAIN: issue     = 1'b0;
         pci_pkg::ST_REPLY: rsp_valid = 1'b1;
         default:           busy      = 1'b1;
      endcase
   end

   // Advance the scan position in row-major order
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (pixel_accept) begin
         row_in = '0;
         col_in = '0;
      end else if (issue) begin
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + RowWidth'(1);
         end else begin
            col_in = col_ff + ColWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pci_pkg::ST_IDLE;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= issue && !hit;
         if (pixel_accept) begin
            found_ff <= 1'b0;
         end else if (hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   // Hold scan position, pixel and compare tags
   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      cmp_row_ff <= row_ff;
      cmp_col_ff <= col_ff;
      if (pixel_accept) begin
         pixel_ff <= req_colour;
      end
      if (hit) begin
         res_row_ff <= cmp_row_ff;
         res_col_ff <= cmp_col_ff;
      end
   end

   // Palette memory: one write port for loads, one registered read for the scan
   always_ff @(posedge clock) begin
      if (load_accept && load_in_range) begin
         palette_mem[AddrWidth'(load_addr_calc)] <= req_colour;
      end
      rd_data_ff <= palette_mem[AddrWidth'(scan_addr_calc)];
   end

   // Build the response
   always_comb begin
      if (found_ff) begin
         rsp_data.out_first  = pci_pkg::CHAN_WIDTH'(res_row_ff);
         rsp_data.out_second = pci_pkg::CHAN_WIDTH'(res_col_ff);
         rsp_data.out_third  = pci_pkg::ZERO_BYTE;
      end else begin
         rsp_data.out_first  = pci_pkg::FULL_BYTE;
         rsp_data.out_second = pci_pkg::ZERO_BYTE;
         rsp_data.out_third  = pci_pkg::FULL_BYTE;
      end
      rsp_data.out_alpha = pci_pkg::FULL_BYTE;
      rsp_data.matched   = found_ff;
   end

`ifndef SYNTHESIS
   // A response is followed by a free request side
   a_rsp_then_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy still high after response");

   // A pixel request makes the block busy
   a_pixel_busy : assert property (@(posedge clock) disable iff (reset)
      pixel_accept |=> busy)
      else $error("pixel request did not start a search");

   // A load request never produces a response
   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      load_accept |=> !rsp_valid)
      else $error("response after load request");

   // A matched response lies inside the active grid
   a_match_in_grid : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.matched) |->
         ((GW'(rsp_data.out_first) < lim_rows) && (GW'(rsp_data.out_second) < lim_cols)))
      else $error("matched entry outside active grid");
`endif

endmodule
